>>> design/ganms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ganms_pkg;

  // Field widths of the request, result and configuration port.
  localparam int REQ_W      = 2;
  localparam int COORD_W    = 12;
  localparam int STR_W      = 16;
  localparam int RANK_W     = 10;
  localparam int IDX_W      = 10;
  localparam int RAD_W      = 24;
  localparam int KEEP_W     = 11;
  localparam int GRID_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int PT_W       = 2 * COORD_W + STR_W;
  localparam int CELL_W     = 2 * GRID_W;

  // Default store depth.
  localparam int MAX_POINTS_DEF = 1024;

  // Grid cell size in pixels and its scaled reciprocal for the cell divide.
  localparam int CELL_SIZE  = 20;
  localparam int RECIP_W    = COORD_W + 1;
  localparam int CELL_RECIP = (1 << COORD_W) / CELL_SIZE;

  localparam logic [RAD_W-1:0] NO_RADIUS = {RAD_W{1'b1}};

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PROC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

  localparam logic [KEEP_W-1:0] KEEP_RST = 11'd500;
  localparam logic [GRID_W-1:0] COLS_RST = 8'd32;
  localparam logic [GRID_W-1:0] ROWS_RST = 8'd24;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [STR_W-1:0]   s;
  } point_t;

  typedef struct packed {
    logic [GRID_W-1:0] cx;
    logic [GRID_W-1:0] cy;
  } cell_t;

endpackage

`default_nettype wire

>>> design/ganms_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel.
interface ganms_req_if;
  import ganms_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [STR_W-1:0]   strength;
  logic [RANK_W-1:0]  rank;

  modport source (output valid, req_type, pos_x, pos_y, strength, rank, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, strength, rank, output ready);
endinterface

// Result channel.
interface ganms_res_if;
  import ganms_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   point_index;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [STR_W-1:0]   out_strength;
  logic [RAD_W-1:0]   radius_sq;
  logic [KEEP_W-1:0]  selected_count;
  logic               rank_valid;
  logic               overflow;

  modport source (output valid, point_index, out_x, out_y, out_strength, radius_sq,
                  selected_count, rank_valid, overflow, input ready);
  modport sink (input valid, point_index, out_x, out_y, out_strength, radius_sq,
                selected_count, rank_valid, overflow, output ready);
endinterface

`default_nettype wire

>>> design/ganms_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
module ganms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/grid_anms_keypoint_select.sv
`timescale 1ns / 1ps
`default_nettype none

// Grid adaptive non-maximal suppression keypoint selector. Add requests store one keypoint
// each while there is room (else the overflow flag is set) and are taken one per cycle while
// the block is idle. A process request sorts the stored points by strength (strongest first,
// stable), computes each point's squared suppression radius against stronger points in
// neighboring grid cells, and ranks the points by radius (largest first, stable). The
// strength sort and the radius ranking each sweep the whole set once per point, the cell
// pass visits each point once, and the radius pass sweeps the earlier points, all through
// the single read port of each memory. A read request passes through the rank lookup and
// the point and radius lookup to the output register, or goes straight to the output
// register when the rank is not selected; no new request is taken until the result is in
// the output register, which waits while an earlier result is still held there.
// The user must write configuration only while the block is idle; the block does not enforce it.
module grid_anms_keypoint_select #(
  parameter int MAX_POINTS = ganms_pkg::MAX_POINTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ganms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ganms_pkg::CFG_DATA_W-1:0] cfg_data,
  ganms_req_if.sink                           req,
  ganms_res_if.source                         res
);
  import ganms_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = (CW > KEEP_W) ? CW : KEEP_W;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_S_HEAD  = 5'd1;
  localparam logic [4:0] ST_S_HLAT  = 5'd2;
  localparam logic [4:0] ST_S_SWEEP = 5'd3;
  localparam logic [4:0] ST_S_WRITE = 5'd4;
  localparam logic [4:0] ST_C_RD    = 5'd5;
  localparam logic [4:0] ST_C_LAT   = 5'd6;
  localparam logic [4:0] ST_C_FIX   = 5'd7;
  localparam logic [4:0] ST_R_HEAD  = 5'd8;
  localparam logic [4:0] ST_R_HLAT  = 5'd9;
  localparam logic [4:0] ST_R_SWEEP = 5'd10;
  localparam logic [4:0] ST_R_WRITE = 5'd11;
  localparam logic [4:0] ST_K_HEAD  = 5'd12;
  localparam logic [4:0] ST_K_HLAT  = 5'd13;
  localparam logic [4:0] ST_K_SWEEP = 5'd14;
  localparam logic [4:0] ST_K_WRITE = 5'd15;
  localparam logic [4:0] ST_K_DONE  = 5'd16;
  localparam logic [4:0] ST_Q_RANK  = 5'd17;
  localparam logic [4:0] ST_Q_PT    = 5'd18;
  localparam logic [4:0] ST_Q_OUT   = 5'd19;

  // Control and configuration registers.
  logic [4:0]        state;
  logic [KEEP_W-1:0] keep_count;
  logic [GRID_W-1:0] grid_cols;
  logic [GRID_W-1:0] grid_rows;
  logic [CW-1:0]     point_count;
  logic              overflow_flag;
  logic              set_processed;
  logic [CW-1:0]     i;
  logic [CW-1:0]     j;
  logic [CW-1:0]     jd;
  logic [CW-1:0]     cnt;
  logic              v1;
  logic              v2;
  logic              out_valid;

  // Datapath registers.
  point_t             cur_pt;
  cell_t              cur_cell;
  logic [RAD_W-1:0]   cur_rad;
  logic [RAD_W-1:0]   acc;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [2*COORD_W-1:0] sqx;
  logic [2*COORD_W-1:0] sqy;
  logic [AW-1:0]      q_idx;
  point_t             q_pt;
  logic [RAD_W-1:0]   q_rad;
  logic               q_hit;
  logic [SW-1:0]      q_sel;
  logic [IDX_W-1:0]   o_idx;
  point_t             o_pt;
  logic [RAD_W-1:0]   o_rad;
  logic [KEEP_W-1:0]  o_sel;
  logic               o_hit;
  logic               o_ovf;

  // Memory ports.
  logic          pt_we;
  logic [AW-1:0] pt_waddr;
  point_t        pt_wdata;
  logic [AW-1:0] pt_raddr;
  point_t        pt_rd;
  logic          scr_we;
  logic [AW-1:0] scr_waddr;
  point_t        scr_rd;
  logic          cell_we;
  cell_t         cell_wdata;
  cell_t         cell_rd;
  logic          rad_we;
  logic [AW-1:0] rad_raddr;
  logic [RAD_W-1:0] rad_rd;
  logic          rank_we;
  logic [AW-1:0] rank_raddr;
  logic [AW-1:0] rank_rd;

  // Request decode.
  logic                 req_fire;
  logic                 add_fire;
  logic [CW-1:0]        eff_count;
  logic                 has_room;
  logic [SW-1:0]        keep_ext;
  logic [SW-1:0]        cnt_ext;
  logic [SW-1:0]        sel;
  logic [SW-1:0]        rank_ext;
  logic [AW+RANK_W-1:0] rank_wide;
  logic [AW+IDX_W-1:0]  idx_wide;
  logic [CW-1:0]        i_inc;
  logic                 i_last;
  logic                 sort_bound;
  logic                 rad_bound;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign add_fire  = req_fire && (req.req_type == REQ_ADD);
  assign eff_count = set_processed ? '0 : point_count;
  assign has_room  = (eff_count < CW'(MAX_POINTS));
  assign keep_ext  = SW'(keep_count);
  assign cnt_ext   = SW'(point_count);
  assign sel       = set_processed ? ((keep_ext < cnt_ext) ? keep_ext : cnt_ext) : '0;
  assign rank_ext  = SW'(req.rank);
  assign rank_wide = (AW + RANK_W)'(req.rank);
  assign i_inc     = i + CW'(1);
  assign i_last    = (i_inc == point_count);
  assign sort_bound = (j < point_count);
  assign rad_bound  = (j < i);

  // Cell index: reciprocal multiply, then one correction step and a clamp to the grid.
  logic [COORD_W+RECIP_W-1:0] px;
  logic [COORD_W+RECIP_W-1:0] py;
  logic [COORD_W+8:0]         mx;
  logic [COORD_W+8:0]         my;
  logic [COORD_W-1:0]         rx;
  logic [COORD_W-1:0]         ry;
  logic [COORD_W-1:0]         cxf;
  logic [COORD_W-1:0]         cyf;
  logic [GRID_W-1:0]          lim_x;
  logic [GRID_W-1:0]          lim_y;

  assign px    = scr_rd.x * RECIP_W'(CELL_RECIP);
  assign py    = scr_rd.y * RECIP_W'(CELL_RECIP);
  assign mx    = qx * 9'(CELL_SIZE);
  assign my    = qy * 9'(CELL_SIZE);
  assign rx    = cur_pt.x - mx[COORD_W-1:0];
  assign ry    = cur_pt.y - my[COORD_W-1:0];
  assign cxf   = ({1'b0, rx} >= (COORD_W + 1)'(CELL_SIZE)) ? qx + COORD_W'(1) : qx;
  assign cyf   = ({1'b0, ry} >= (COORD_W + 1)'(CELL_SIZE)) ? qy + COORD_W'(1) : qy;
  assign lim_x = (grid_cols == '0) ? '0 : grid_cols - GRID_W'(1);
  assign lim_y = (grid_rows == '0) ? '0 : grid_rows - GRID_W'(1);
  assign cell_wdata.cx = (COORD_W'(lim_x) < cxf) ? lim_x : cxf[GRID_W-1:0];
  assign cell_wdata.cy = (COORD_W'(lim_y) < cyf) ? lim_y : cyf[GRID_W-1:0];

  // Radius candidate: strictly stronger point in the same or an adjacent cell.
  logic [GRID_W-1:0]  dcx;
  logic [GRID_W-1:0]  dcy;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic               cand;
  logic [2*COORD_W:0] dist_sq;

  assign dcx  = (cur_cell.cx > cell_rd.cx) ? cur_cell.cx - cell_rd.cx : cell_rd.cx - cur_cell.cx;
  assign dcy  = (cur_cell.cy > cell_rd.cy) ? cur_cell.cy - cell_rd.cy : cell_rd.cy - cur_cell.cy;
  assign dx   = (cur_pt.x > pt_rd.x) ? cur_pt.x - pt_rd.x : pt_rd.x - cur_pt.x;
  assign dy   = (cur_pt.y > pt_rd.y) ? cur_pt.y - pt_rd.y : pt_rd.y - cur_pt.y;
  assign cand = (cur_pt.s < pt_rd.s) && (dcx <= GRID_W'(1)) && (dcy <= GRID_W'(1));
  assign dist_sq = {1'b0, sqx} + {1'b0, sqy};

  // Memory address and write selection.
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = eff_count[AW-1:0];
    pt_wdata = cur_pt;
    pt_raddr = '0;
    rad_raddr = '0;
    if (add_fire && has_room) begin
      pt_we       = 1'b1;
      pt_wdata.x  = req.pos_x;
      pt_wdata.y  = req.pos_y;
      pt_wdata.s  = req.strength;
    end else if (state == ST_C_FIX) begin
      pt_we    = 1'b1;
      pt_waddr = i[AW-1:0];
    end
    case (state)
      ST_S_HEAD, ST_R_HEAD:   pt_raddr = i[AW-1:0];
      ST_S_SWEEP, ST_R_SWEEP: pt_raddr = j[AW-1:0];
      ST_Q_RANK:              pt_raddr = rank_rd;
      default:                pt_raddr = '0;
    endcase
    case (state)
      ST_K_HEAD:  rad_raddr = i[AW-1:0];
      ST_K_SWEEP: rad_raddr = j[AW-1:0];
      ST_Q_RANK:  rad_raddr = rank_rd;
      default:    rad_raddr = '0;
    endcase
  end

  assign scr_we     = (state == ST_S_WRITE);
  assign scr_waddr  = cnt[AW-1:0];
  assign cell_we    = (state == ST_C_FIX);
  assign rad_we     = (state == ST_R_WRITE);
  assign rank_we    = (state == ST_K_WRITE);
  assign rank_raddr = rank_wide[AW-1:0];

  ganms_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
    .rd_addr(pt_raddr), .rd_data(pt_rd)
  );

  ganms_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_scr_ram (
    .clk(clk), .wr_en(scr_we), .wr_addr(scr_waddr), .wr_data(cur_pt),
    .rd_addr(i[AW-1:0]), .rd_data(scr_rd)
  );

  ganms_ram #(.WIDTH(CELL_W), .DEPTH(MAX_POINTS)) u_cell_ram (
    .clk(clk), .wr_en(cell_we), .wr_addr(i[AW-1:0]), .wr_data(cell_wdata),
    .rd_addr(pt_raddr), .rd_data(cell_rd)
  );

  ganms_ram #(.WIDTH(RAD_W), .DEPTH(MAX_POINTS)) u_rad_ram (
    .clk(clk), .wr_en(rad_we), .wr_addr(i[AW-1:0]), .wr_data(acc),
    .rd_addr(rad_raddr), .rd_data(rad_rd)
  );

  ganms_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_rank_ram (
    .clk(clk), .wr_en(rank_we), .wr_addr(cnt[AW-1:0]), .wr_data(i[AW-1:0]),
    .rd_addr(rank_raddr), .rd_data(rank_rd)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RST;
      grid_cols  <= COLS_RST;
      grid_rows  <= ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KEEP: keep_count <= cfg_data;
        CFG_COLS: grid_cols  <= cfg_data[GRID_W-1:0];
        CFG_ROWS: grid_rows  <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_Q_OUT && (!out_valid || res.ready)) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign idx_wide = (AW + IDX_W)'(q_idx);

  always_ff @(posedge clk) begin
    if (state == ST_Q_OUT && (!out_valid || res.ready)) begin
      o_idx <= q_hit ? idx_wide[IDX_W-1:0] : '0;
      o_pt  <= q_hit ? q_pt : '0;
      o_rad <= q_hit ? q_rad : '0;
      o_sel <= q_sel[KEEP_W-1:0];
      o_hit <= q_hit;
      o_ovf <= overflow_flag;
    end
  end

  assign res.valid          = out_valid;
  assign res.point_index    = o_idx;
  assign res.out_x          = o_pt.x;
  assign res.out_y          = o_pt.y;
  assign res.out_strength   = o_pt.s;
  assign res.radius_sq      = o_rad;
  assign res.selected_count = o_sel;
  assign res.rank_valid     = o_hit;
  assign res.overflow       = o_ovf;

  // Sequencer for adds, processing and reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      point_count   <= '0;
      overflow_flag <= 1'b0;
      set_processed <= 1'b0;
      i             <= '0;
      j             <= '0;
      jd            <= '0;
      cnt           <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            case (req.req_type)
              REQ_ADD: begin
                set_processed <= 1'b0;
                if (has_room) begin
                  point_count   <= eff_count + CW'(1);
                  overflow_flag <= set_processed ? 1'b0 : overflow_flag;
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              REQ_PROC: begin
                i     <= '0;
                state <= (point_count == '0) ? ST_K_DONE : ST_S_HEAD;
              end
              REQ_READ: begin
                q_sel <= sel;
                q_hit <= (rank_ext < sel);
                state <= (rank_ext < sel) ? ST_Q_RANK : ST_Q_OUT;
              end
              default: ;
            endcase
          end
        end

        // Strength sort: the sorted place of a point is the count of points ahead of it.
        ST_S_HEAD: state <= ST_S_HLAT;
        ST_S_HLAT: begin
          cur_pt <= pt_rd;
          j      <= '0;
          cnt    <= '0;
          v1     <= 1'b0;
          state  <= ST_S_SWEEP;
        end
        ST_S_SWEEP: begin
          v1 <= sort_bound;
          jd <= j;
          if (sort_bound) begin
            j <= j + CW'(1);
          end
          if (v1 && ((pt_rd.s > cur_pt.s) || (pt_rd.s == cur_pt.s && jd < i))) begin
            cnt <= cnt + CW'(1);
          end
          if (!sort_bound && !v1) begin
            state <= ST_S_WRITE;
          end
        end
        ST_S_WRITE: begin
          i     <= i_last ? '0 : i_inc;
          state <= i_last ? ST_C_RD : ST_S_HEAD;
        end

        // Copy the sorted set back and compute grid cells.
        ST_C_RD: state <= ST_C_LAT;
        ST_C_LAT: begin
          cur_pt <= scr_rd;
          qx     <= px[COORD_W +: COORD_W];
          qy     <= py[COORD_W +: COORD_W];
          state  <= ST_C_FIX;
        end
        ST_C_FIX: begin
          i     <= i_last ? '0 : i_inc;
          state <= i_last ? ST_R_HEAD : ST_C_RD;
        end

        // Radius: minimum squared distance over earlier, stronger neighbors.
        ST_R_HEAD: state <= ST_R_HLAT;
        ST_R_HLAT: begin
          cur_pt   <= pt_rd;
          cur_cell <= cell_rd;
          j        <= '0;
          acc      <= NO_RADIUS;
          v1       <= 1'b0;
          v2       <= 1'b0;
          state    <= ST_R_SWEEP;
        end
        ST_R_SWEEP: begin
          v1 <= rad_bound;
          if (rad_bound) begin
            j <= j + CW'(1);
          end
          v2  <= v1 && cand;
          sqx <= dx * dx;
          sqy <= dy * dy;
          if (v2 && (dist_sq < {1'b0, acc})) begin
            acc <= dist_sq[RAD_W-1:0];
          end
          if (!rad_bound && !v1 && !v2) begin
            state <= ST_R_WRITE;
          end
        end
        ST_R_WRITE: begin
          i     <= i_last ? '0 : i_inc;
          state <= i_last ? ST_K_HEAD : ST_R_HEAD;
        end

        // Ranking by radius, largest first, ties to the lower index.
        ST_K_HEAD: state <= ST_K_HLAT;
        ST_K_HLAT: begin
          cur_rad <= rad_rd;
          j       <= '0;
          cnt     <= '0;
          v1      <= 1'b0;
          state   <= ST_K_SWEEP;
        end
        ST_K_SWEEP: begin
          v1 <= sort_bound;
          jd <= j;
          if (sort_bound) begin
            j <= j + CW'(1);
          end
          if (v1 && ((rad_rd > cur_rad) || (rad_rd == cur_rad && jd < i))) begin
            cnt <= cnt + CW'(1);
          end
          if (!sort_bound && !v1) begin
            state <= ST_K_WRITE;
          end
        end
        ST_K_WRITE: begin
          i     <= i_last ? '0 : i_inc;
          state <= i_last ? ST_K_DONE : ST_K_HEAD;
        end
        ST_K_DONE: begin
          set_processed <= 1'b1;
          state         <= ST_IDLE;
        end

        // Read back: rank entry, then the point and its radius.
        ST_Q_RANK: begin
          q_idx <= rank_rd;
          state <= ST_Q_PT;
        end
        ST_Q_PT: begin
          q_pt  <= pt_rd;
          q_rad <= rad_rd;
          state <= ST_Q_OUT;
        end
        ST_Q_OUT: begin
          if (!out_valid || res.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/grid_anms_keypoint_select_tb.sv
`timescale 1ns / 1ps

module grid_anms_keypoint_select_tb;
  import ganms_pkg::*;

  // Request code that the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [STR_W-1:0]   s;
    logic [RANK_W-1:0]  rank;
  } keypoint_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   point_index;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [STR_W-1:0]   out_strength;
    logic [RAD_W-1:0]   radius_sq;
    logic [KEEP_W-1:0]  selected_count;
    logic               rank_valid;
    logic               overflow;
  } selection_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ganms_req_if req_ch ();
  ganms_res_if res_ch ();

  grid_anms_keypoint_select uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (req_ch.sink),
    .res      (res_ch.source)
  );

  keypoint_req_t pending_reqs[$];
  selection_t    expected_sel[$];
  keypoint_req_t driven_req;
  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int last_set_size;

  // Shadow of the block's configuration and stores.
  logic [KEEP_W-1:0]  keep_r;
  logic [GRID_W-1:0]  cols_r;
  logic [GRID_W-1:0]  rows_r;
  logic [COORD_W-1:0] kp_x[DEPTH];
  logic [COORD_W-1:0] kp_y[DEPTH];
  logic [STR_W-1:0]   kp_s[DEPTH];
  logic [RAD_W-1:0]   kp_rad[DEPTH];
  int                 kp_cx[DEPTH];
  int                 kp_cy[DEPTH];
  int                 by_radius[DEPTH];
  int                 loaded;
  bit                 ovf_r;
  bit                 processed_r;

  function automatic int cell_of(int p, int n);
    int lim;
    int c;
    lim = (n == 0) ? 0 : n - 1;
    c = p / CELL_SIZE;
    return (c > lim) ? lim : c;
  endfunction

  function automatic int absdiff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Sort by strength, compute suppression radii, then rank by radius.
  function automatic void select_keypoints();
    int i;
    int j;
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [STR_W-1:0]   vs;
    longint r;
    longint dx;
    longint dy;
    longint d;
    for (i = 0; i < loaded; i++) begin
      vx = kp_x[i];
      vy = kp_y[i];
      vs = kp_s[i];
      j = i;
      while (j > 0 && kp_s[j-1] < vs) begin
        kp_x[j] = kp_x[j-1];
        kp_y[j] = kp_y[j-1];
        kp_s[j] = kp_s[j-1];
        j--;
      end
      kp_x[j] = vx;
      kp_y[j] = vy;
      kp_s[j] = vs;
    end
    for (i = 0; i < loaded; i++) begin
      kp_cx[i] = cell_of(int'(kp_x[i]), int'(cols_r));
      kp_cy[i] = cell_of(int'(kp_y[i]), int'(rows_r));
    end
    for (i = 0; i < loaded; i++) begin
      r = 64'hFFFFFF;
      for (j = 0; j < i; j++) begin
        if (kp_s[i] < kp_s[j] && absdiff(kp_cx[i], kp_cx[j]) <= 1 &&
            absdiff(kp_cy[i], kp_cy[j]) <= 1) begin
          dx = absdiff(int'(kp_x[i]), int'(kp_x[j]));
          dy = absdiff(int'(kp_y[i]), int'(kp_y[j]));
          d = dx * dx + dy * dy;
          if (d < r) r = d;
        end
      end
      kp_rad[i] = r[RAD_W-1:0];
    end
    for (i = 0; i < loaded; i++) begin
      j = i;
      while (j > 0 && kp_rad[by_radius[j-1]] < kp_rad[i]) begin
        by_radius[j] = by_radius[j-1];
        j--;
      end
      by_radius[j] = i;
    end
    processed_r = 1;
    last_set_size = loaded;
  endfunction

  // Update the shadow state for one accepted request.
  function automatic void apply_request(keypoint_req_t rq);
    selection_t res;
    int sel;
    int p;
    case (rq.kind)
      REQ_ADD: begin
        if (processed_r) begin
          loaded = 0;
          ovf_r = 0;
          processed_r = 0;
        end
        if (loaded >= DEPTH) begin
          ovf_r = 1;
        end else begin
          kp_x[loaded] = rq.x;
          kp_y[loaded] = rq.y;
          kp_s[loaded] = rq.s;
          loaded++;
        end
      end
      REQ_PROC: begin
        select_keypoints();
      end
      REQ_READ: begin
        res = '0;
        sel = 0;
        if (processed_r) sel = (int'(keep_r) < loaded) ? int'(keep_r) : loaded;
        if (int'(rq.rank) < sel) begin
          p = by_radius[rq.rank];
          res.point_index = p[IDX_W-1:0];
          res.out_x = kp_x[p];
          res.out_y = kp_y[p];
          res.out_strength = kp_s[p];
          res.radius_sq = kp_rad[p];
          res.rank_valid = 1'b1;
        end
        res.selected_count = sel[KEEP_W-1:0];
        res.overflow = ovf_r;
        expected_sel.insert(expected_sel.size(), res);
      end
      default: begin
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request driver: a new request is presented once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) apply_request(driven_req);
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        driven_req = pending_reqs.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= driven_req.kind;
        req_ch.pos_x    <= driven_req.x;
        req_ch.pos_y    <= driven_req.y;
        req_ch.strength <= driven_req.s;
        req_ch.rank     <= driven_req.rank;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    selection_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_sel.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %0d", $time,
                   res_ch.point_index);
          errors++;
        end else begin
          want = expected_sel.pop_front();
          check_field("point_index", want.point_index, res_ch.point_index);
          check_field("out_x", want.out_x, res_ch.out_x);
          check_field("out_y", want.out_y, res_ch.out_y);
          check_field("out_strength", want.out_strength, res_ch.out_strength);
          check_field("radius_sq", want.radius_sq, res_ch.radius_sq);
          check_field("selected_count", want.selected_count, res_ch.selected_count);
          check_field("rank_valid", want.rank_valid, res_ch.rank_valid);
          check_field("overflow", want.overflow, res_ch.overflow);
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_req(logic [REQ_W-1:0] kind, int x, int y, int s, int rank);
    keypoint_req_t rq;
    rq.kind = kind;
    rq.x = COORD_W'(x);
    rq.y = COORD_W'(y);
    rq.s = STR_W'(s);
    rq.rank = RANK_W'(rank);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Wait until every request is taken and answered, then let processing finish.
  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_sel.size() > 0)
      @(posedge clk);
    repeat (3 * last_set_size * last_set_size + 20 * last_set_size + 50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEEP: keep_r = KEEP_W'(value);
      CFG_COLS: cols_r = GRID_W'(value);
      default:  rows_r = GRID_W'(value);
    endcase
  endtask

  // One keypoint set: clustered or spread points, a process, then reads.
  task automatic queue_set();
    int n;
    int bx;
    int by;
    int spread;
    int smax;
    int k;
    n = ($urandom_range(11) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
    bx = $urandom_range(4095);
    by = $urandom_range(4095);
    spread = ($urandom_range(3) == 0) ? 4095 : $urandom_range(5, 80);
    smax = ($urandom_range(1) == 0) ? 7 : 65535;
    for (int i = 0; i < n; i++) begin
      queue_req(REQ_ADD, (bx + $urandom_range(spread)) % 4096,
                (by + $urandom_range(spread)) % 4096, $urandom_range(smax), 0);
      if ($urandom_range(40) == 0) queue_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
    end
    if ($urandom_range(7) == 0) queue_req(REQ_READ, 0, 0, 0, 0);
    queue_req(REQ_PROC, $urandom, $urandom, $urandom, $urandom);
    k = $urandom_range(1, (n < 12) ? n + 2 : 12);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(5) == 0) queue_req(REQ_READ, 0, 0, 0, $urandom_range(1023));
      else queue_req(REQ_READ, 0, 0, 0, $urandom_range(n + 1));
    end
  endtask

  initial begin
    int phase_keep[6];
    int phase_cols[6];
    int phase_rows[6];
    int phase_send[6];
    int phase_recv[6];
    int start_len;
    errors = 0;
    last_set_size = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    keep_r = KEEP_RST;
    cols_r = COLS_RST;
    rows_r = ROWS_RST;
    loaded = 0;
    ovf_r = 0;
    processed_r = 0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.strength = '0;
    req_ch.rank = '0;
    res_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: read before any process, empty set, ignored code, edge points and ties.
    queue_req(REQ_READ, 0, 0, 0, 0);
    queue_req(REQ_PROC, 0, 0, 0, 0);
    queue_req(REQ_READ, 0, 0, 0, 0);
    queue_req(REQ_UNUSED, 4095, 4095, 65535, 1023);
    queue_req(REQ_ADD, 0, 0, 0, 0);
    queue_req(REQ_ADD, 4095, 4095, 65535, 0);
    queue_req(REQ_ADD, 10, 10, 100, 0);
    queue_req(REQ_ADD, 15, 12, 100, 0);
    queue_req(REQ_ADD, 30, 25, 200, 0);
    queue_req(REQ_ADD, 4095, 0, 65535, 0);
    queue_req(REQ_ADD, 0, 4095, 1, 0);
    queue_req(REQ_ADD, 4000, 4090, 300, 0);
    queue_req(REQ_PROC, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++) queue_req(REQ_READ, 0, 0, 0, i);
    queue_req(REQ_READ, 0, 0, 0, 1023);
    drain();

    // Phases of configuration and idling.
    phase_keep = '{500, 1024, 0, 1, 5, 3};
    phase_cols = '{32, 204, 1, 1, 3, 204};
    phase_rows = '{24, 204, 1, 204, 2, 1};
    phase_send = '{0, 71, 0, 28, 0, 71};
    phase_recv = '{0, 0, 71, 28, 0, 71};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_KEEP, (ph == 4) ? $urandom_range(0, 40) : phase_keep[ph]);
        write_reg(CFG_COLS, phase_cols[ph]);
        write_reg(CFG_ROWS, (ph == 4) ? $urandom_range(1, 10) : phase_rows[ph]);
      end
      send_idle_pct = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      start_len = 0;
      while (start_len < 130) begin
        queue_set();
        start_len += pending_reqs.size();
        while (pending_reqs.size() > 0) @(posedge clk);
      end
      drain();
    end

    // Full store: adds beyond capacity are dropped and flagged.
    write_reg(CFG_KEEP, 1024);
    send_idle_pct = 0;
    recv_stall_pct = 28;
    queue_req(REQ_PROC, 0, 0, 0, 0);
    for (int i = 0; i < DEPTH + 1; i++)
      queue_req(REQ_ADD, $urandom_range(4095), $urandom_range(4095), $urandom_range(65535), 0);
    queue_req(REQ_READ, 0, 0, 0, 0);
    queue_req(REQ_ADD, 1, 2, 3, 0);
    queue_req(REQ_READ, 0, 0, 0, $urandom_range(1023));
    while (pending_reqs.size() > 0 || req_ch.valid || expected_sel.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
